// ===== hdl/mits_pkg.sv =====
// Shared types and constants for the multi-interval tick scheduler.
package mits_pkg;

    localparam int SLOT_COUNT     = 8;
    localparam int INTERVAL_WIDTH = 16;
    localparam int ELAPSED_WIDTH  = INTERVAL_WIDTH + 1;
    localparam int STEP_W         = $clog2(SLOT_COUNT + 1);
    localparam int SHIFT_W        = $clog2(INTERVAL_WIDTH + 1);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef logic [INTERVAL_WIDTH-1:0] interval_t;
    typedef logic [ELAPSED_WIDTH-1:0]  elapsed_t;

    typedef struct packed {
        logic      valid;
        interval_t interval;
        elapsed_t  elapsed;
    } slot_rec_t;

    typedef struct packed {
        logic shift;
        logic set;
        logic clr;
    } cell_ctl_t;

endpackage

// ===== hdl/mits_cell.sv =====
// One slot of the ring: valid bit, interval and elapsed count.
module mits_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mits_pkg::cell_ctl_t   ctl,
    input  mits_pkg::interval_t   set_interval,
    input  mits_pkg::slot_rec_t   rec_in,
    output mits_pkg::slot_rec_t   rec
);
    import mits_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    interval_t interval_reg;
    interval_t interval_next;
    elapsed_t  elapsed_reg;
    elapsed_t  elapsed_next;

    always_comb
    begin
        valid_next    = valid_reg;
        interval_next = interval_reg;
        elapsed_next  = elapsed_reg;
        if (ctl.set)
        begin
            valid_next    = 1'b1;
            interval_next = set_interval;
            elapsed_next  = '0;
        end
        else if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next    = rec_in.valid;
            interval_next = rec_in.interval;
            elapsed_next  = rec_in.elapsed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        interval_reg <= interval_next;
        elapsed_reg  <= elapsed_next;
    end

    assign rec.valid    = valid_reg;
    assign rec.interval = interval_reg;
    assign rec.elapsed  = elapsed_reg;

endmodule

// ===== hdl/mits_gcd.sv =====
// Iterative binary GCD, one reduction step per cycle.
module mits_gcd (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mits_pkg::interval_t a,
    input  mits_pkg::interval_t b,
    output logic                done,
    output mits_pkg::interval_t result
);
    import mits_pkg::*;

    interval_t            a_reg;
    interval_t            a_next;
    interval_t            b_reg;
    interval_t            b_next;
    logic [SHIFT_W-1:0]   k_reg;
    logic [SHIFT_W-1:0]   k_next;
    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    interval_t            res_reg;
    interval_t            res_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (a_reg == '0)
            begin
                res_next  = interval_t'(b_reg << k_reg);
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else if (b_reg == '0)
            begin
                res_next  = interval_t'(a_reg << k_reg);
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hdl/multi_interval_tick_scheduler.sv =====
// Top level: slot ring, walk sequencer, GCD unit and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  command  | start in, busy out   | cmd, slot, interval_ms
//  result   | strobe out           | fire, fired_slot, base_tick_ms, last
//
// A tick walks the ring once, results one per cycle at most.
// Add/remove walk the ring once and run the binary GCD unit for each valid slot
// after the first.
// Unused commands and out-of-range slots give their single result the cycle after start.
// Reset clears all valid bits and the base tick; the ring is aligned whenever idle.
// Results are shown for one cycle only; the receiver cannot stall.
module multi_interval_tick_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [2:0]  slot,
    input  logic [15:0] interval_ms,
    output logic        strobe,
    output logic        fire,
    output logic [2:0]  fired_slot,
    output logic [15:0] base_tick_ms,
    output logic        last
);
    import mits_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_TICK     = 3'd1;
    localparam logic [2:0] ST_TICK_END = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_GCD      = 3'd4;
    localparam logic [2:0] ST_CFG_END  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [2:0]        pend_slot_reg;
    logic [2:0]        pend_slot_next;
    logic              any_reg;
    logic              any_next;
    interval_t         g_reg;
    interval_t         g_next;
    interval_t         base_reg;
    interval_t         base_next;
    logic              strobe_reg;
    logic              fire_reg;
    logic [2:0]        fired_slot_reg;
    interval_t         out_base_reg;
    logic              last_reg;

    slot_rec_t         rec_vec [SLOT_COUNT];
    slot_rec_t         ring_in [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_vec;
    slot_rec_t         head;
    slot_rec_t         head_upd;
    elapsed_t          sum;
    logic              due;
    logic              accept;
    logic              in_range;
    logic              shift;
    logic              last_step;
    interval_t         wr_interval;
    interval_t         new_base;
    logic              gcd_start;
    logic              gcd_done;
    interval_t         gcd_result;

    logic              emit;
    logic              emit_fire;
    logic [2:0]        emit_slot;
    logic              emit_last;
    interval_t         emit_base;

    assign accept      = start && !busy;
    assign in_range    = 32'(slot) < SLOT_COUNT;
    assign wr_interval = interval_t'(interval_ms);
    assign head        = rec_vec[0];
    assign sum         = head.elapsed + elapsed_t'(base_reg);
    assign due         = sum >= elapsed_t'(head.interval);
    assign last_step   = 32'(step_reg) == SLOT_COUNT - 1;
    assign new_base    = !any_reg ? '0 : ((g_reg == '0) ? interval_t'(1) : g_reg);

    always_comb
    begin
        head_upd = head;
        if (state_reg == ST_TICK && head.valid)
        begin
            head_upd.elapsed = due ? '0 : sum;
        end
    end

    // ring: each cell takes its upper neighbor, the top cell takes the updated head
    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            cell_ctl_t ctl;

            if (gi == SLOT_COUNT - 1)
            begin : g_top
                assign ring_in[gi] = head_upd;
            end
            else
            begin : g_mid
                assign ring_in[gi] = rec_vec[gi+1];
            end

            assign ctl.shift = shift;
            assign ctl.set   = accept && cmd == CMD_ADD && 32'(slot) == gi;
            assign ctl.clr   = accept && cmd == CMD_REMOVE && 32'(slot) == gi;
            assign valid_vec[gi] = rec_vec[gi].valid;

            mits_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .set_interval (wr_interval),
                .rec_in       (ring_in[gi]),
                .rec          (rec_vec[gi])
            );
        end
    endgenerate

    mits_gcd u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .a      (g_reg),
        .b      (head.interval),
        .done   (gcd_done),
        .result (gcd_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        any_next        = any_reg;
        g_next          = g_reg;
        base_next       = base_reg;
        shift           = 1'b0;
        gcd_start       = 1'b0;
        emit            = 1'b0;
        emit_fire       = 1'b0;
        emit_slot       = '0;
        emit_last       = 1'b1;
        emit_base       = base_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_TICK:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = ST_TICK;
                        end
                        CMD_ADD, CMD_REMOVE:
                        begin
                            if (in_range)
                            begin
                                any_next   = 1'b0;
                                g_next     = '0;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                shift = 1'b1;
                if (head.valid && due)
                begin
                    // hold each fire one step so the final one can carry last
                    if (pend_valid_reg)
                    begin
                        emit      = 1'b1;
                        emit_fire = 1'b1;
                        emit_slot = pend_slot_reg;
                        emit_last = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = 3'(step_reg);
                end
                if (last_step)
                begin
                    state_next = ST_TICK_END;
                end
            end
            ST_TICK_END:
            begin
                emit       = 1'b1;
                emit_fire  = pend_valid_reg;
                emit_slot  = pend_valid_reg ? pend_slot_reg : 3'd0;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (head.valid && any_reg)
                begin
                    gcd_start  = 1'b1;
                    state_next = ST_GCD;
                end
                else
                begin
                    shift = 1'b1;
                    if (head.valid)
                    begin
                        g_next   = head.interval;
                        any_next = 1'b1;
                    end
                    if (last_step)
                    begin
                        state_next = ST_CFG_END;
                    end
                end
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    g_next     = gcd_result;
                    shift      = 1'b1;
                    state_next = last_step ? ST_CFG_END : ST_SCAN;
                end
            end
            ST_CFG_END:
            begin
                base_next  = new_base;
                emit       = 1'b1;
                emit_base  = new_base;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (shift)
        begin
            step_next = last_step ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            base_reg       <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            any_reg        <= any_next;
            base_reg       <= base_next;
            strobe_reg     <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        g_reg         <= g_next;
        if (emit)
        begin
            fire_reg       <= emit_fire;
            fired_slot_reg <= emit_slot;
            out_base_reg   <= emit_base;
            last_reg       <= emit_last;
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign strobe       = strobe_reg;
    assign fire         = fire_reg;
    assign fired_slot   = fired_slot_reg;
    assign base_tick_ms = 16'(out_base_reg);
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_done |-> state_reg == ST_GCD)
        else $error("gcd result arrived outside the gcd wait state");

    a_ring_aligned_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> step_reg == '0)
        else $error("slot ring not aligned while idle");

    a_zero_base_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && base_reg == '0) |-> valid_vec == '0)
        else $error("base tick zero with a valid slot");

    a_tick_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK_END |=> strobe && last)
        else $error("tick walk ended without a final transfer");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for multi_interval_tick_scheduler: random and directed commands vs. a slot model.
`timescale 1ns / 1ps

module tb_top;

    import mits_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 260;

    typedef struct {
        logic       fire;
        logic [2:0] slot;
        interval_t  base;
        logic       last;
    } sched_result_t;

    // Mirrors the slot table and base tick; turns each command into the results it should give.
    class slot_table_predictor;
        bit            slot_on [SLOT_COUNT];
        interval_t     period [SLOT_COUNT];
        elapsed_t      count [SLOT_COUNT];
        interval_t     base_tick;
        sched_result_t due_results [$];
        int            mismatch_count;

        function new();
            foreach (slot_on[i])
            begin
                slot_on[i] = 1'b0;
                period[i]  = '0;
                count[i]   = '0;
            end
            base_tick      = '0;
            mismatch_count = 0;
        endfunction

        function interval_t gcd_of(interval_t a, interval_t b);
            interval_t t;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function void refresh_base();
            bit        any;
            interval_t g;
            any = 1'b0;
            g   = '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (slot_on[i])
                begin
                    g   = any ? gcd_of(g, period[i]) : period[i];
                    any = 1'b1;
                end
            end
            if (!any)
                base_tick = '0;
            else
                base_tick = (g == 0) ? interval_t'(1) : g;
        endfunction

        function void push_result(logic f, logic [2:0] s, logic l);
            sched_result_t r;
            r.fire = f;
            r.slot = s;
            r.base = base_tick;
            r.last = l;
            due_results = {due_results, r};
        endfunction

        function void log_command(logic [1:0] c, logic [2:0] s, interval_t iv);
            int due_slots [$];
            if (c == CMD_ADD || c == CMD_REMOVE)
            begin
                if (s < SLOT_COUNT)
                begin
                    if (c == CMD_ADD)
                    begin
                        slot_on[s] = 1'b1;
                        period[s]  = iv;
                        count[s]   = '0;
                    end
                    else
                        slot_on[s] = 1'b0;
                    refresh_base();
                end
                push_result(1'b0, 3'd0, 1'b1);
            end
            else if (c == CMD_TICK)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_on[i])
                    begin
                        count[i] = count[i] + base_tick;
                        if (count[i] >= {1'b0, period[i]})
                        begin
                            count[i] = '0;
                            due_slots = {due_slots, i};
                        end
                    end
                end
                if (due_slots.size() == 0)
                    push_result(1'b0, 3'd0, 1'b1);
                foreach (due_slots[k])
                    push_result(1'b1, due_slots[k][2:0], k == due_slots.size() - 1);
            end
            else
                push_result(1'b0, 3'd0, 1'b1);
        endfunction

        function void check_result(logic f, logic [2:0] s, interval_t b, logic l);
            sched_result_t e;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: fire=%b slot=%0d base=%0d last=%b",
                         $time, f, s, b, l);
                mismatch_count++;
                return;
            end
            e = due_results.pop_front();
            if (f !== e.fire)
            begin
                $display("%0t: fire expected %b actual %b", $time, e.fire, f);
                mismatch_count++;
            end
            if (s !== e.slot)
            begin
                $display("%0t: fired_slot expected %0d actual %0d", $time, e.slot, s);
                mismatch_count++;
            end
            if (b !== e.base)
            begin
                $display("%0t: base_tick_ms expected %0d actual %0d", $time, e.base, b);
                mismatch_count++;
            end
            if (l !== e.last)
            begin
                $display("%0t: last expected %b actual %b", $time, e.last, l);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic [15:0] interval_ms;
    logic        strobe;
    logic        fire;
    logic [2:0]  fired_slot;
    logic [15:0] base_tick_ms;
    logic        last;

    slot_table_predictor sched_model = new();
    int                  idle_pct;
    int unsigned         family;

    multi_interval_tick_scheduler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .slot         (slot),
        .interval_ms  (interval_ms),
        .strobe       (strobe),
        .fire         (fire),
        .fired_slot   (fired_slot),
        .base_tick_ms (base_tick_ms),
        .last         (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe === 1'b1)
                sched_model.check_result(fire, fired_slot, base_tick_ms, last);
            if (start === 1'b1 && busy === 1'b0)
                sched_model.log_command(cmd, slot, interval_ms);
        end
    end

    // Called at a falling edge; returns at a falling edge with start possibly still high.
    task automatic send_command(input logic [1:0] c, input logic [2:0] s, input interval_t iv);
        int gap;
        start       <= 1'b1;
        cmd         <= c;
        slot        <= s;
        interval_ms <= iv;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sched_model.pending() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_command();
        int          pick;
        int          mode;
        logic [1:0]  c;
        logic [2:0]  s;
        interval_t   iv;
        pick = $urandom_range(0, 99);
        s    = 3'($urandom_range(0, 7));
        iv   = interval_t'($urandom_range(0, 65535));
        if (pick < 45)
            c = CMD_TICK;
        else if (pick < 80)
        begin
            c    = CMD_ADD;
            mode = $urandom_range(0, 99);
            if (mode < 2)
                iv = '0;
            else if (mode < 12)
                iv = interval_t'($urandom_range(1, 65535));
            else
                iv = interval_t'(family * $urandom_range(1, 12));
        end
        else if (pick < 97)
            c = CMD_REMOVE;
        else
            c = CMD_UNUSED;
        send_command(c, s, iv);
    endtask

    initial
    begin
        int phase_idle [4];
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_TICK;
        slot        = 3'd0;
        interval_ms = 16'd0;
        idle_pct    = 0;
        family      = 3;
        phase_idle  = '{0, 62, 0, 12};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // tick and remove on an empty table, then an unused command
        send_command(CMD_TICK, 3'd0, 16'h0000);
        send_command(CMD_REMOVE, 3'd3, 16'h0000);
        send_command(CMD_UNUSED, 3'd5, 16'hFFFF);
        // zero interval alone forces base 1 and fires every tick
        send_command(CMD_ADD, 3'd0, 16'h0000);
        send_command(CMD_TICK, 3'd0, 16'h0000);
        send_command(CMD_ADD, 3'd7, 16'hFFFF);
        send_command(CMD_TICK, 3'd0, 16'h0000);
        send_command(CMD_REMOVE, 3'd0, 16'h0000);
        send_command(CMD_TICK, 3'd0, 16'h0000);
        for (int i = 0; i < 7; i++)
            send_command(CMD_ADD, i[2:0], 16'd3);
        // replace slot 7, then every slot fires on one tick
        send_command(CMD_ADD, 3'd7, 16'd3);
        send_command(CMD_TICK, 3'd0, 16'h0000);
        send_command(CMD_ADD, 3'd2, 16'hAAAA);
        send_command(CMD_TICK, 3'd0, 16'h5555);
        send_command(CMD_ADD, 3'd5, 16'h8000);
        send_command(CMD_REMOVE, 3'd2, 16'h0000);
        send_command(CMD_REMOVE, 3'd7, 16'h0000);
        send_command(CMD_TICK, 3'd0, 16'h0000);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            for (int n = 0; n < 99; n++)
            begin
                if (n % 33 == 0)
                    family = $urandom_range(0, 1) ? $urandom_range(1, 15) : $urandom_range(1, 5461);
                send_random_command();
            end
            // sender holds off until the table has answered everything
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sched_model.mismatch_count == 0 && sched_model.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
